FILE: src/cbd_pkg.sv
package cbd_pkg;

  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam int unsigned DigitBits = 4;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    PH_LEAD   = 8'b0000_0001,
    PH_DIGITS = 8'b0000_0010,
    PH_TAIL   = 8'b0000_0100,
    PH_EXT    = 8'b0000_1000,
    PH_BAD    = 8'b0001_0000,
    PH_DATA   = 8'b0010_0000,
    PH_TERM   = 8'b0100_0000,
    PH_TRAIL  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    kind_e      out_kind;
  } res_t;

  typedef struct packed {
    logic fresh;
  } stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  // bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [DigitBits:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
      return {1'b1, v[DigitBits-1:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
      return {1'b1, v[DigitBits-1:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
      return {1'b1, v[DigitBits-1:0]};
    end
    return '0;
  endfunction

endpackage

FILE: src/cbd_in_if.sv
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

FILE: src/cbd_out_if.sv
interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;

  modport source (output valid, out_byte, out_kind, input ready);
  modport sink (input valid, out_byte, out_kind, output ready);
endinterface

FILE: src/chunked_body_decoder.sv
// Chunked HTTP/1.1 body decoder.
// Input channel in_i carries one raw stream word per handshake: in_byte, or an
// end_of_stream mark whose byte is ignored. Output channel out_o carries at most
// one word per input word: a body byte (out_kind 0), body complete (1) or a
// framing error (2). Size lines, chunk terminators and trailers give no word.
// Throughput: one input word per cycle, sustained, while out_o takes its words.
// An accepted word is loaded into the input register; the parser step then
// updates its state and loads the result register, which drives out_o.valid.
// Reset clears both stage valids and returns the parser to await a new body.
// After a complete or an error word the parser restarts on the next byte.
// When out_o stalls, a held result stays put and the input register fills;
// in_i.ready then drops until out_o takes its word.
// COUNT_BITS sets the chunk size counter; larger sizes are framing errors.
module chunked_body_decoder import cbd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbd_in_if.sink    in_i,
  cbd_out_if.source out_o
);

  logic  s1_valid;
  item_t s1_item;
  item_t in_item;
  res_t  step_res;
  res_t  out_res;
  stat_t step_stat;
  logic  advance;
  logic  load;

  assign in_item = '{in_byte: in_i.in_byte, end_of_stream: in_i.end_of_stream};
  assign advance = s1_valid && (!out_res.valid || out_o.ready);
  assign in_i.ready = !s1_valid || advance;
  assign load = in_i.valid && in_i.ready;

  cbd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .advance_i (advance),
    .item_i    (in_item),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  cbd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item),
    .res_o     (step_res),
    .stat_o    (step_stat)
  );

  cbd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ready_i   (out_o.ready),
    .res_i     (step_res),
    .res_o     (out_res)
  );

  assign out_o.valid    = out_res.valid;
  assign out_o.out_byte = out_res.out_byte;
  assign out_o.out_kind = out_res.out_kind;

  a_restart_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_res.valid && step_res.out_kind != KIND_BODY |=> step_stat.fresh)
    else $error("parser not restarted after complete or error word");

  a_stop_clears_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && out_res.out_kind != KIND_BODY |-> out_res.out_byte == 8'h00)
    else $error("non-body word carries a byte");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register lost a word while stalled");

endmodule

FILE: src/cbd_in_stage.sv
module cbd_in_stage import cbd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  logic  advance_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/cbd_step.sv
module cbd_step import cbd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  item_t item_i,
  output res_t  res_o,
  output stat_t stat_o
);

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic                  digit_q, digit_d;
  logic                  text_q, text_d;

  always_comb begin
    logic [7:0]           c;
    logic [DigitBits:0]   nib;
    logic                 restart;
    c       = item_i.in_byte;
    nib     = hex_nibble(c);
    restart = 1'b0;
    phase_d = phase_q;
    rem_d   = rem_q;
    digit_d = digit_q;
    text_d  = text_q;
    res_o   = '{valid: 1'b0, out_byte: 8'h00, out_kind: KIND_BODY};

    if (item_i.end_of_stream) begin
      res_o.valid    = 1'b1;
      res_o.out_kind = KIND_ERROR;
      restart        = 1'b1;
    end else begin
      case (phase_q)
        PH_LEAD, PH_DIGITS, PH_TAIL, PH_EXT, PH_BAD: begin
          if (c == ChLf) begin
            if (phase_q == PH_BAD || !digit_q) begin
              res_o.valid    = 1'b1;
              res_o.out_kind = KIND_ERROR;
              restart        = 1'b1;
            end else begin
              digit_d = 1'b0;
              text_d  = 1'b0;
              phase_d = (rem_q == '0) ? PH_TRAIL : PH_DATA;
            end
          end else if (phase_q == PH_EXT || phase_q == PH_BAD) begin
            phase_d = phase_q;
          end else if (c == ChSemi) begin
            phase_d = PH_EXT;
          end else if (is_space(c)) begin
            if (phase_q == PH_DIGITS) begin
              phase_d = PH_TAIL;
            end
          end else if (nib[DigitBits] && phase_q != PH_TAIL) begin
            if (rem_q[COUNT_BITS-1 -: DigitBits] != '0) begin
              phase_d = PH_BAD;
            end else begin
              rem_d   = {rem_q[COUNT_BITS-DigitBits-1:0], nib[DigitBits-1:0]};
              digit_d = 1'b1;
              phase_d = PH_DIGITS;
            end
          end else begin
            phase_d = PH_BAD;
          end
        end
        PH_DATA: begin
          rem_d          = rem_q - COUNT_BITS'(1);
          res_o.valid    = 1'b1;
          res_o.out_byte = c;
          res_o.out_kind = KIND_BODY;
          if (rem_d == '0) begin
            phase_d = PH_TERM;
            text_d  = 1'b0;
          end
        end
        PH_TERM: begin
          if (c == ChLf) begin
            if (text_q) begin
              res_o.valid    = 1'b1;
              res_o.out_kind = KIND_ERROR;
            end
            restart = 1'b1;
          end else if (!is_space(c)) begin
            text_d = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (c == ChLf) begin
            if (!text_q) begin
              res_o.valid    = 1'b1;
              res_o.out_kind = KIND_DONE;
              restart        = 1'b1;
            end else begin
              text_d = 1'b0;
            end
          end else if (!is_space(c)) begin
            text_d = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end

    if (restart) begin
      phase_d = PH_LEAD;
      rem_d   = '0;
      digit_d = 1'b0;
      text_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      rem_q   <= '0;
      digit_q <= 1'b0;
      text_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      digit_q <= digit_d;
      text_q  <= text_d;
    end
  end

  assign stat_o.fresh = (phase_q == PH_LEAD) && (rem_q == '0) && !digit_q && !text_q;

endmodule

FILE: src/cbd_out_stage.sv
module cbd_out_stage import cbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic ready_i,
  input  res_t res_i,
  output res_t res_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  kind_e      kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= res_i.valid;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_i.valid) begin
      byte_q <= res_i.out_byte;
      kind_q <= res_i.out_kind;
    end
  end

  assign res_o = '{valid: valid_q, out_byte: byte_q, out_kind: kind_q};

endmodule

FILE: test/chunked_body_decoder_test.sv
`timescale 1ns / 100ps

module chunked_body_decoder_test;
  import cbd_pkg::*;

  localparam int unsigned CountBits = 32;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned HoldAfterWords = 60;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } body_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cbd_in_if  in_if ();
  cbd_out_if out_if ();

  chunked_body_decoder #(
    .COUNT_BITS(CountBits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  item_t       stream_q[$];
  item_t       body_buf[$];
  body_word_t  due_words[$];
  item_t       next_item;
  body_word_t  due_word;
  int unsigned queued;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors = 0;
  int unsigned words_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  bit          hold_done = 1'b0;

  phase_e                 dec_phase;
  logic [CountBits-1:0]   dec_left;
  logic                   dec_digit;
  logic                   dec_text;

  always #5 clk_i = ~clk_i;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  // bit 4 marks a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'h00;
  endfunction

  task automatic restart_decode();
    dec_phase = PH_LEAD;
    dec_left  = '0;
    dec_digit = 1'b0;
    dec_text  = 1'b0;
  endtask

  task automatic close_body(input kind_e k);
    body_word_t w;
    w.data = 8'h00;
    w.kind = k;
    due_words.push_back(w);
    restart_decode();
  endtask

  task automatic predict_decode(input item_t it);
    logic [7:0] c;
    logic [4:0] hx;
    body_word_t w;
    c  = it.in_byte;
    hx = hex_digit_of(c);
    if (it.end_of_stream) begin
      close_body(KIND_ERROR);
      return;
    end
    case (dec_phase)
      PH_DATA: begin
        dec_left = dec_left - CountBits'(1);
        if (dec_left == '0) begin
          dec_phase = PH_TERM;
          dec_text  = 1'b0;
        end
        w.data = c;
        w.kind = KIND_BODY;
        due_words.push_back(w);
      end
      PH_TERM: begin
        if (c == ChLf) begin
          if (dec_text) close_body(KIND_ERROR);
          else restart_decode();
        end else if (!is_blank(c)) begin
          dec_text = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (c == ChLf) begin
          if (!dec_text) close_body(KIND_DONE);
          else dec_text = 1'b0;
        end else if (!is_blank(c)) begin
          dec_text = 1'b1;
        end
      end
      default: begin
        if (c == ChLf) begin
          if (dec_phase == PH_BAD || !dec_digit) begin
            close_body(KIND_ERROR);
          end else begin
            dec_digit = 1'b0;
            dec_text  = 1'b0;
            dec_phase = (dec_left == '0) ? PH_TRAIL : PH_DATA;
          end
        end else if (dec_phase != PH_EXT && dec_phase != PH_BAD) begin
          if (c == ChSemi) begin
            dec_phase = PH_EXT;
          end else if (is_blank(c)) begin
            if (dec_phase == PH_DIGITS) dec_phase = PH_TAIL;
          end else if (hx[4] && dec_phase != PH_TAIL) begin
            if (dec_left[CountBits-1 -: 4] != 4'h0) begin
              dec_phase = PH_BAD;
            end else begin
              dec_left  = {dec_left[CountBits-5:0], hx[3:0]};
              dec_digit = 1'b1;
              dec_phase = PH_DIGITS;
            end
          end else begin
            dec_phase = PH_BAD;
          end
        end
      end
    endcase
  endtask

  task automatic put(input logic [7:0] b);
    item_t it;
    it.in_byte       = b;
    it.end_of_stream = 1'b0;
    body_buf.push_back(it);
  endtask

  // byte is don't-care on an end mark, so randomise it
  task automatic put_eos();
    item_t it;
    it.in_byte       = 8'($urandom_range(255));
    it.end_of_stream = 1'b1;
    body_buf.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_blanks(input int unsigned n);
    logic [7:0] pick;
    repeat (n) begin
      case ($urandom_range(4))
        0: pick = 8'h20;
        1: pick = 8'h09;
        2: pick = 8'h0B;
        3: pick = 8'h0C;
        default: pick = 8'h0D;
      endcase
      put(pick);
    end
  endtask

  function automatic logic [7:0] rand_text();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == ChLf) b = 8'h2D;
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic put_size_line(input int unsigned size);
    int unsigned nd;
    put_blanks($urandom_range(2));
    repeat (($urandom_range(7) == 0) ? $urandom_range(9, 1) : $urandom_range(1)) put(8'h30);
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    for (int i = int'(nd) - 1; i >= 0; i--) put(hex_char(4'(size >> (4 * i))));
    put_blanks($urandom_range(2));
    if ($urandom_range(3) == 0) begin
      put(ChSemi);
      repeat ($urandom_range(4)) put(rand_text());
    end
    put(ChLf);
  endtask

  task automatic queue_body();
    foreach (body_buf[i]) stream_q.push_back(body_buf[i]);
    queued += body_buf.size();
    body_buf.delete();
  endtask

  task automatic add_random_body();
    int unsigned size;
    int unsigned pos;
    item_t       it;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(8, 1)) put(8'($urandom_range(255)));
      put_eos();
    end else begin
      repeat ($urandom_range(3)) begin
        size = ($urandom_range(7) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        put_size_line(size);
        repeat (size) put(8'($urandom_range(255)));
        put_blanks($urandom_range(2));
        put(ChLf);
      end
      put_size_line(0);
      repeat ($urandom_range(2)) begin
        put(8'h54);
        repeat ($urandom_range(6)) put(rand_text());
        put(ChLf);
      end
      put_blanks($urandom_range(1));
      put(ChLf);
      if ($urandom_range(4) == 0) begin
        pos = $urandom_range(body_buf.size() - 1);
        case ($urandom_range(3))
          0: body_buf[pos].in_byte = 8'($urandom_range(255));
          1: begin
            it.in_byte       = 8'($urandom_range(255));
            it.end_of_stream = 1'b0;
            body_buf.insert(pos, it);
          end
          2: while (body_buf.size() > pos) void'(body_buf.pop_back());
          default: begin
            body_buf.delete();
            put(hex_char(4'($urandom_range(15, 1))));
            repeat ($urandom_range(9, 8)) put(hex_char(4'($urandom_range(15))));
            put(ChLf);
          end
        endcase
        put_eos();
      end else if ($urandom_range(15) == 0) begin
        put_eos();
      end
    end
    queue_body();
  endtask

  task automatic wait_stream_empty();
    while (stream_q.size() != 0 || in_if.valid) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      restart_decode();
    end else begin
      if (in_if.valid && in_if.ready) begin
        next_item.in_byte       = in_if.in_byte;
        next_item.end_of_stream = in_if.end_of_stream;
        predict_decode(next_item);
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = stream_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.in_byte       <= next_item.in_byte;
          in_if.end_of_stream <= next_item.end_of_stream;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        if (due_words.size() == 0) begin
          $error("unexpected word: out_byte %0h out_kind %0d", out_if.out_byte, out_if.out_kind);
          errors++;
        end else begin
          due_word = due_words.pop_front();
          if (out_if.out_byte !== due_word.data) begin
            $error("out_byte: expected %0h, got %0h", due_word.data, out_if.out_byte);
            errors++;
          end
          if (out_if.out_kind !== due_word.kind) begin
            $error("out_kind: expected %0d, got %0d", due_word.kind, out_if.out_kind);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && words_seen >= HoldAfterWords) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    queued               = 0;
    send_idle_pct        = 20;
    recv_idle_pct        = 66;

    put_eos();
    put_text("\n");
    put_text("2;x\n");
    put(8'h00);
    put(8'hFF);
    put_text(" \r\n0\n\n");
    put_text("1 2\n");
    put_text("fffffffff\n");
    put_text("1\n");
    put(8'h41);
    put_text("x\n");
    queue_body();
    while (queued < 330) add_random_body();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_stream_empty();

    send_idle_pct = 66;
    recv_idle_pct = 20;
    while (queued < 640) add_random_body();
    wait_stream_empty();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (queued < 950) add_random_body();
    wait_stream_empty();

    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
